// ===== rtl/core/ple_pkg.sv =====
// shared types and constants for the positional list engine
package ple_pkg;

  // action codes
  localparam logic [2:0] ACT_PUSH     = 3'd0;
  localparam logic [2:0] ACT_POP      = 3'd1;
  localparam logic [2:0] ACT_INSERT   = 3'd2;
  localparam logic [2:0] ACT_DELETE   = 3'd3;
  localparam logic [2:0] ACT_RETRIEVE = 3'd4;
  localparam logic [2:0] ACT_REPLACE  = 3'd5;
  localparam logic [2:0] ACT_CLEAR    = 3'd6;
  localparam logic [2:0] ACT_TRAVERSE = 3'd7;

  // position code meaning append on insert
  localparam logic [6:0] POS_APPEND = 7'h7F;

  // read value returned by pop on an empty list
  localparam logic [15:0] ERR_WORD = 16'hFC19;

  // most results a traverse streams
  localparam int OUT_LIMIT = 32;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // one result item
  typedef struct packed {
    logic signed [15:0] read_first;
    logic signed [15:0] read_second;
    status_t            status;
    logic [5:0]         count;
    logic               is_empty;
    logic               last;
  } res_t;

endpackage

// ===== rtl/core/ple_store.sv =====
// entry store: one write port and one registered read port
module ple_store #(
  parameter int CAPACITY = 32,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/ple_ctrl.sv =====
// sequencer: decodes one action and walks the store one entry move at a time
module ple_ctrl #(
  parameter int CAPACITY = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          action,
  input  logic signed [6:0]   position,
  input  logic signed [15:0]  entry_first,
  input  logic signed [15:0]  entry_second,
  input  logic                res_ready,
  output logic                res_push,
  output ple_pkg::res_t       res,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [31:0]         wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [31:0]         rd_data
);

  localparam int CMPW = (CW > 6) ? CW : 6;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SHR   = 9'b000000010,
    S_SHW   = 9'b000000100,
    S_GET   = 9'b000001000,
    S_SHL   = 9'b000010000,
    S_SHLW  = 9'b000100000,
    S_TRD   = 9'b001000000,
    S_TEMIT = 9'b010000000,
    S_RES   = 9'b100000000
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     pidx, pidx_next;
  logic [2:0]        op, op_next;
  logic [31:0]       ent, ent_next;
  logic [5:0]        lim, lim_next;
  logic [15:0]       rf, rf_next;
  logic [15:0]       rs, rs_next;
  ple_pkg::status_t  code, code_next;
  logic              rlast, rlast_next;

  logic              accept;
  logic              pos_neg;
  logic [CMPW-1:0]   pos_ext;
  logic [CMPW-1:0]   cnt_ext;
  logic [CMPW-1:0]   idx_inc;
  logic              full;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign pos_neg  = position[6];
  assign pos_ext  = CMPW'(position[5:0]);
  assign cnt_ext  = CMPW'(cnt);
  assign idx_inc  = CMPW'(idx) + CMPW'(1);
  assign full     = (cnt == CW'(CAPACITY));

  // result seen by the output register, count taken after the operation
  always_comb begin
    res.read_first  = rf;
    res.read_second = rs;
    res.status      = code;
    res.count       = cnt_ext[5:0];
    res.is_empty    = (cnt == '0);
    res.last        = rlast;
  end

  // next-state logic and store port control
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    pidx_next  = pidx;
    op_next    = op;
    ent_next   = ent;
    lim_next   = lim;
    rf_next    = rf;
    rs_next    = rs;
    code_next  = code;
    rlast_next = rlast;
    res_push   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx[AW-1:0];
    wr_data    = ent;
    rd_en      = 1'b0;
    rd_addr    = idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next    = action;
          ent_next   = {entry_first, entry_second};
          rf_next    = '0;
          rs_next    = '0;
          code_next  = ple_pkg::ST_OK;
          rlast_next = 1'b1;
          idx_next   = cnt;
          pidx_next  = pos_ext[CW-1:0];
          state_next = S_RES;
          case (action)
            ple_pkg::ACT_PUSH, ple_pkg::ACT_INSERT: begin
              if (full) begin
                code_next = ple_pkg::ST_FULL;
              end else if (action == ple_pkg::ACT_PUSH || position == ple_pkg::POS_APPEND) begin
                pidx_next  = cnt;
                state_next = S_SHR;
              end else if (pos_neg || pos_ext > cnt_ext) begin
                code_next = ple_pkg::ST_RANGE;
              end else begin
                state_next = S_SHR;
              end
            end
            ple_pkg::ACT_POP: begin
              if (cnt == '0) begin
                rf_next   = ple_pkg::ERR_WORD;
                rs_next   = ple_pkg::ERR_WORD;
                code_next = ple_pkg::ST_EMPTY;
              end else begin
                pidx_next  = cnt - CW'(1);
                rd_en      = 1'b1;
                rd_addr    = pidx_next[AW-1:0];
                state_next = S_GET;
              end
            end
            ple_pkg::ACT_DELETE, ple_pkg::ACT_RETRIEVE, ple_pkg::ACT_REPLACE: begin
              if (cnt == '0) begin
                code_next = ple_pkg::ST_EMPTY;
              end else if (pos_neg || pos_ext >= cnt_ext) begin
                code_next = ple_pkg::ST_RANGE;
              end else if (action == ple_pkg::ACT_REPLACE) begin
                wr_en   = 1'b1;
                wr_addr = pos_ext[AW-1:0];
                wr_data = {entry_first, entry_second};
              end else begin
                rd_en      = 1'b1;
                rd_addr    = pos_ext[AW-1:0];
                state_next = S_GET;
              end
            end
            ple_pkg::ACT_CLEAR: begin
              cnt_next = '0;
            end
            default: begin
              // traverse
              if (cnt == '0) begin
                code_next = ple_pkg::ST_EMPTY;
              end else begin
                idx_next   = '0;
                lim_next   = (cnt_ext >= CMPW'(ple_pkg::OUT_LIMIT)) ?
                             6'(ple_pkg::OUT_LIMIT) : cnt_ext[5:0];
                state_next = S_TRD;
              end
            end
          endcase
        end
      end

      // open a gap: move entries up from the tail down to the target
      S_SHR: begin
        if (idx == pidx) begin
          wr_en      = 1'b1;
          wr_addr    = pidx[AW-1:0];
          cnt_next   = cnt + CW'(1);
          state_next = S_RES;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(idx - CW'(1));
          state_next = S_SHW;
        end
      end

      S_SHW: begin
        wr_en      = 1'b1;
        wr_data    = rd_data;
        idx_next   = idx - CW'(1);
        state_next = S_SHR;
      end

      // target entry is back from the store
      S_GET: begin
        rf_next = rd_data[31:16];
        rs_next = rd_data[15:0];
        if (op == ple_pkg::ACT_RETRIEVE) begin
          state_next = S_RES;
        end else begin
          idx_next   = pidx;
          state_next = S_SHL;
        end
      end

      // close the gap: move later entries down one place
      S_SHL: begin
        if (idx_inc >= cnt_ext) begin
          cnt_next   = cnt - CW'(1);
          state_next = S_RES;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = idx_inc[AW-1:0];
          state_next = S_SHLW;
        end
      end

      S_SHLW: begin
        wr_en      = 1'b1;
        wr_data    = rd_data;
        idx_next   = idx + CW'(1);
        state_next = S_SHL;
      end

      // traverse: fetch one entry
      S_TRD: begin
        rd_en      = 1'b1;
        state_next = S_TEMIT;
      end

      S_TEMIT: begin
        rf_next    = rd_data[31:16];
        rs_next    = rd_data[15:0];
        rlast_next = (idx_inc == CMPW'(lim));
        state_next = S_RES;
      end

      // hand the result to the output register
      S_RES: begin
        if (res_ready) begin
          res_push = 1'b1;
          if (rlast) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = S_TRD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx   <= idx_next;
    pidx  <= pidx_next;
    op    <= op_next;
    ent   <= ent_next;
    lim   <= lim_next;
    rf    <= rf_next;
    rs    <= rs_next;
    code  <= code_next;
    rlast <= rlast_next;
  end

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Positional list engine: an ordered list of up to CAPACITY signed 16-bit pairs with push,
// pop, insert, delete, retrieve, replace, clear and traverse. One action is taken at a time
// (in_stall is high while an action is in progress). Entries live in a single-port-write,
// registered-read memory, so insert and delete move one entry at a time, with a read and then
// a write for each entry moved. Traverse streams min(count,32) results, each read from the
// store and then handed to the output register; the final one carries last. Results pass
// through an output register, so the engine can finish the next result while one waits.
module positional_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic signed [6:0]  position,
  input  logic signed [15:0] entry_first,
  input  logic signed [15:0] entry_second,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] read_first,
  output logic signed [15:0] read_second,
  output logic [1:0]         status,
  output logic [5:0]         count,
  output logic               is_empty,
  output logic               last
);

  localparam int AW = $clog2(CAPACITY);

  logic           in_ready;
  logic           res_ready;
  logic           res_push;
  ple_pkg::res_t  res;
  ple_pkg::res_t  out_q;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [31:0]    wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [31:0]    rd_data;

  assign in_stall  = !in_ready;
  assign res_ready = !out_valid || !out_stall;

  ple_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .position     (position),
    .entry_first  (entry_first),
    .entry_second (entry_second),
    .res_ready    (res_ready),
    .res_push     (res_push),
    .res          (res),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  ple_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign read_first  = out_q.read_first;
  assign read_second = out_q.read_second;
  assign status      = out_q.status;
  assign count       = out_q.count;
  assign is_empty    = out_q.is_empty;
  assign last        = out_q.last;

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == 6'd0)))
    else $error("is_empty disagrees with count");

  // failed requests end the run at once
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ple_pkg::ST_OK) |-> last)
    else $error("error result without last");

  // full status only when the list holds CAPACITY entries
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ple_pkg::ST_FULL) |-> (count == 6'(CAPACITY)))
    else $error("full status with list not full");

  // no new transfer is taken while a result is still being produced
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");

endmodule
